// ===== sv/acs_pkg.sv =====
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types and constants of the accumulator machine: beat payloads,
// opcodes and command codes.
// ----------------------------------------------------------------------------
package acs_pkg;

  // default depth of the word memory
  localparam int unsigned MEM_WORDS_DEF = 4096;

  localparam int unsigned WORD_W   = 16;
  localparam int unsigned ADDR_W   = 12;
  localparam int unsigned IMM_W    = 12;
  localparam int unsigned OP_W     = 4;
  // address bit that selects the character ports
  localparam int unsigned PORT_BIT = 14;

  // item commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // instruction opcodes (top nibble)
  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 4'd0,
    OP_LOADI  = 4'd1,
    OP_STOREI = 4'd2,
    OP_IMM    = 4'd3,
    OP_STORE  = 4'd4,
    OP_ADD    = 4'd5,
    OP_NOPA   = 4'd6,
    OP_AND    = 4'd7,
    OP_OR     = 4'd8,
    OP_XOR    = 4'd9,
    OP_SHR    = 4'd10,
    OP_JMP    = 4'd11,
    OP_BZ     = 4'd12,
    OP_NOPB   = 4'd13,
    OP_CALL   = 4'd14,
    OP_JMPI   = 4'd15
  } opcode_t;

  // input beat
  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
    logic [WORD_W-1:0] in_char;
  } acs_in_t;

  // result beat
  typedef struct packed {
    logic              out_valid;
    logic [WORD_W-1:0] out_data;
    logic              in_taken;
    logic              halted;
    logic [WORD_W-1:0] pc_now;
    logic [WORD_W-1:0] acc_now;
  } acs_out_t;

endpackage

// ===== sv/acs_addr_mod.sv =====
// ----------------------------------------------------------------------------
// acs_addr_mod
// Shared address reducer: folds a 16-bit address into the word memory
// range (address modulo MEM_WORDS) by a constant reciprocal multiply, done
// in the cycle after start for an in-range address, else after a busy step.
// ----------------------------------------------------------------------------
module acs_addr_mod #(
  parameter int unsigned MEM_WORDS = acs_pkg::MEM_WORDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [acs_pkg::WORD_W-1:0]       value,
  output logic                             done,
  output logic [$clog2(MEM_WORDS)-1:0]     result
);

  localparam int unsigned WW = acs_pkg::WORD_W;
  localparam int unsigned AW = $clog2(MEM_WORDS);
  // quotient bits needed for any 16-bit value
  localparam int unsigned QW = 17 - AW;
  // ceil(2^(16+AW) / MEM_WORDS) gives the exact quotient of any 16-bit value
  localparam int unsigned SH = WW + AW;
  localparam int unsigned PW = 2 * WW + 1;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SH) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS);
  localparam logic [PW-1:0] RECIP = PW'(RECIP_L);
  localparam logic [WW-1:0] DIV   = WW'(MEM_WORDS);

  logic          busy_r;
  logic          done_r;
  logic [WW-1:0] val_r;
  logic [WW-1:0] rem_r;
  logic [QW-1:0] quo_r;

  logic [PW-1:0] prod;
  logic [WW-1:0] quo_mul;

  // quotient by constant multiply, then back to a multiple of the depth
  assign prod    = PW'(value) * RECIP;
  assign quo_mul = WW'(quo_r) * DIV;

  // control: in-range values finish at once, others pass the busy state first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      busy_r <= 1'b0;
      if (start) begin
        if (value < DIV) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        done_r <= 1'b1;
      end
    end
  end

  // datapath: quotient first, remainder the cycle after
  always_ff @(posedge clk) begin
    if (start) begin
      val_r <= value;
      rem_r <= value;
      quo_r <= prod[SH +: QW];
    end else if (busy_r) begin
      rem_r <= val_r - quo_mul;
    end
  end

  assign done   = done_r;
  assign result = rem_r[AW-1:0];

endmodule

// ===== sv/accumulator_cpu_step.sv =====
// ----------------------------------------------------------------------------
// accumulator_cpu_step
// 16-bit accumulator machine: program word writes and single instruction
// steps over one single-port word memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps the word memory to zero, one word a cycle,
// with in_stall high during the sweep (configuration writes are taken
// during the sweep). After that one item is in work at a time. Every later
// memory access goes through the shared address reducer and the single
// memory port: the reducer is started and S_MOD waits for its done, which
// takes the reducer's busy step when the address is not below MEM_WORDS,
// and a read then passes S_READ for its registered data. A step while
// halted goes straight to S_DONE. Results sit in an output register so the
// next item can be taken while the last result waits.
// ----------------------------------------------------------------------------
module accumulator_cpu_step #(
  parameter int unsigned MEM_WORDS = acs_pkg::MEM_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  acs_pkg::acs_in_t              in_beat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output acs_pkg::acs_out_t             out_beat,
  input  logic                          cfg_we,
  input  logic [acs_pkg::ADDR_W-1:0]    cfg_wdata
);

  localparam int unsigned AW = $clog2(MEM_WORDS);
  localparam int unsigned WW = acs_pkg::WORD_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_READ,
    S_DONE
  } state_t;

  // what the pending memory access is for
  typedef enum logic [2:0] {
    K_LOAD,
    K_FETCH,
    K_OPND,
    K_IND,
    K_WR
  } kind_t;

  state_t                      state_r;
  kind_t                       kind_r;
  logic [AW-1:0]               clr_cnt_r;
  logic [WW-1:0]               pc_r;
  logic [WW-1:0]               acc_r;
  logic                        halt_r;
  acs_pkg::opcode_t            op_r;
  logic [WW-1:0]               wdata_r;
  logic [WW-1:0]               in_char_r;
  logic                        mod_start_r;
  logic [WW-1:0]               mod_val_r;
  logic                        res_ov_r;
  logic [WW-1:0]               res_od_r;
  logic                        res_it_r;
  logic                        out_valid_r;
  acs_pkg::acs_out_t           out_beat_r;

  logic [WW-1:0]               mem [MEM_WORDS];
  logic [WW-1:0]               rdata_r;

  logic                        mod_done;
  logic [AW-1:0]               mod_res;
  logic                        mem_hit;
  logic                        mem_re;
  logic                        mem_we;
  logic [AW-1:0]               mem_addr;
  logic [WW-1:0]               mem_wdata;
  acs_pkg::opcode_t            rd_op;
  logic [WW-1:0]               rd_imm;
  logic [WW-1:0]               pc_inc;

  // shared address reducer
  acs_addr_mod #(
    .MEM_WORDS (MEM_WORDS)
  ) u_addr_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mod_start_r),
    .value  (mod_val_r),
    .done   (mod_done),
    .result (mod_res)
  );

  // memory port control
  assign mem_hit   = (state_r == S_MOD) && mod_done;
  assign mem_re    = mem_hit && ((kind_r == K_FETCH) || (kind_r == K_OPND) ||
                                 (kind_r == K_IND));
  assign mem_we    = (state_r == S_CLEAR) ||
                     (mem_hit && ((kind_r == K_LOAD) || (kind_r == K_WR)));
  assign mem_addr  = (state_r == S_CLEAR) ? clr_cnt_r : mod_res;
  assign mem_wdata = (state_r == S_CLEAR) ? '0 : wdata_r;

  // word memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  // decode of the fetched word
  assign rd_op  = acs_pkg::opcode_t'(rdata_r[WW-1:WW-acs_pkg::OP_W]);
  assign rd_imm = WW'(rdata_r[acs_pkg::IMM_W-1:0]);
  assign pc_inc = pc_r + 1'b1;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      pc_r        <= '0;
      acc_r       <= '0;
      halt_r      <= 1'b0;
      mod_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mod_start_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      // start value loads pc and acc
      if (cfg_we) begin
        pc_r  <= WW'(cfg_wdata);
        acc_r <= WW'(cfg_wdata);
      end
      unique case (state_r)
        // zero sweep after reset
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == AW'(MEM_WORDS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        // take a beat
        S_IDLE: begin
          if (in_valid) begin
            in_char_r <= in_beat.in_char;
            res_ov_r  <= 1'b0;
            res_od_r  <= '0;
            res_it_r  <= 1'b0;
            if (in_beat.cmd == acs_pkg::CMD_WRITE) begin
              kind_r      <= K_LOAD;
              wdata_r     <= in_beat.data;
              mod_val_r   <= WW'(in_beat.addr);
              mod_start_r <= 1'b1;
              state_r     <= S_MOD;
            end else if (halt_r) begin
              state_r <= S_DONE;
            end else begin
              kind_r      <= K_FETCH;
              mod_val_r   <= pc_r;
              mod_start_r <= 1'b1;
              state_r     <= S_MOD;
            end
          end
        end
        // wait for the reduced address, access memory
        S_MOD: begin
          if (mod_done) begin
            state_r <= ((kind_r == K_LOAD) || (kind_r == K_WR)) ? S_DONE : S_READ;
          end
        end
        // read data is back
        S_READ: begin
          unique case (kind_r)
            K_FETCH: begin
              op_r <= rd_op;
              unique case (rd_op)
                acs_pkg::OP_LOAD, acs_pkg::OP_LOADI, acs_pkg::OP_STOREI,
                acs_pkg::OP_ADD, acs_pkg::OP_AND, acs_pkg::OP_OR,
                acs_pkg::OP_XOR, acs_pkg::OP_JMPI: begin
                  kind_r      <= K_OPND;
                  mod_val_r   <= rd_imm;
                  mod_start_r <= 1'b1;
                  state_r     <= S_MOD;
                end
                acs_pkg::OP_IMM: begin
                  acc_r   <= rd_imm;
                  pc_r    <= pc_inc;
                  state_r <= S_DONE;
                end
                acs_pkg::OP_STORE: begin
                  kind_r      <= K_WR;
                  wdata_r     <= acc_r;
                  mod_val_r   <= rd_imm;
                  mod_start_r <= 1'b1;
                  pc_r        <= pc_inc;
                  state_r     <= S_MOD;
                end
                acs_pkg::OP_CALL: begin
                  kind_r      <= K_WR;
                  wdata_r     <= pc_r;
                  mod_val_r   <= rd_imm;
                  mod_start_r <= 1'b1;
                  pc_r        <= rd_imm + 1'b1;
                  state_r     <= S_MOD;
                end
                acs_pkg::OP_SHR: begin
                  acc_r   <= acc_r >> 1;
                  pc_r    <= pc_inc;
                  state_r <= S_DONE;
                end
                // jump to itself halts
                acs_pkg::OP_JMP: begin
                  if (pc_r == rd_imm) begin
                    halt_r <= 1'b1;
                  end
                  pc_r    <= rd_imm;
                  state_r <= S_DONE;
                end
                acs_pkg::OP_BZ: begin
                  pc_r    <= (acc_r == '0) ? rd_imm : pc_inc;
                  state_r <= S_DONE;
                end
                acs_pkg::OP_NOPA, acs_pkg::OP_NOPB: begin
                  pc_r    <= pc_inc;
                  state_r <= S_DONE;
                end
              endcase
            end
            K_OPND: begin
              state_r <= S_DONE;
              pc_r    <= pc_inc;
              unique case (op_r)
                acs_pkg::OP_LOAD: acc_r <= rdata_r;
                acs_pkg::OP_ADD:  acc_r <= acc_r + rdata_r;
                acs_pkg::OP_AND:  acc_r <= acc_r & rdata_r;
                acs_pkg::OP_OR:   acc_r <= acc_r | rdata_r;
                acs_pkg::OP_XOR:  acc_r <= acc_r ^ rdata_r;
                acs_pkg::OP_JMPI: pc_r  <= rdata_r;
                // indirect load, input port or second read
                acs_pkg::OP_LOADI: begin
                  if (rdata_r[acs_pkg::PORT_BIT]) begin
                    acc_r    <= in_char_r;
                    res_it_r <= 1'b1;
                  end else begin
                    kind_r      <= K_IND;
                    mod_val_r   <= rdata_r;
                    mod_start_r <= 1'b1;
                    state_r     <= S_MOD;
                  end
                end
                // indirect store, memory always and output port maybe
                acs_pkg::OP_STOREI: begin
                  if (rdata_r[acs_pkg::PORT_BIT]) begin
                    res_ov_r <= 1'b1;
                    res_od_r <= acc_r;
                  end
                  kind_r      <= K_WR;
                  wdata_r     <= acc_r;
                  mod_val_r   <= rdata_r;
                  mod_start_r <= 1'b1;
                  state_r     <= S_MOD;
                end
                default: begin
                  state_r <= S_DONE;
                end
              endcase
            end
            K_IND: begin
              acc_r   <= rdata_r;
              state_r <= S_DONE;
            end
            default: begin
              state_r <= S_DONE;
            end
          endcase
        end
        // hand the result to the output register
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r          <= 1'b1;
            out_beat_r.out_valid <= res_ov_r;
            out_beat_r.out_data  <= res_od_r;
            out_beat_r.in_taken  <= res_it_r;
            out_beat_r.halted    <= halt_r;
            out_beat_r.pc_now    <= pc_r;
            out_beat_r.acc_now   <= acc_r;
            state_r              <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

// ===== sv/acs_port_check.sv =====
// ----------------------------------------------------------------------------
// acs_port_check
// Port-level checks of the accumulator machine result channel, bound to the
// top level.
// ----------------------------------------------------------------------------
module acs_port_check (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input acs_pkg::acs_out_t out_beat
);

  logic seen_halt_r;

  // remember a delivered halted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_halt_r <= 1'b0;
    end else if (out_valid && !out_stall && out_beat.halted) begin
      seen_halt_r <= 1'b1;
    end
  end

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("result beat changed while stalled");

  // halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_halt_r |-> out_beat.halted)
    else $error("halt flag dropped without reset");

  // output word is zero unless the port was written
  a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_beat.out_valid |-> out_beat.out_data == '0)
    else $error("output word nonzero without port write");

  // one step never both reads and writes a port
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_beat.out_valid && out_beat.in_taken))
    else $error("input read and output write in one step");

  // halted machine touches no port
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.halted |-> !out_beat.out_valid && !out_beat.in_taken)
    else $error("port activity while halted");

endmodule

bind accumulator_cpu_step acs_port_check u_acs_port_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_beat  (out_beat)
);
